FILE: src/geodetic_to_ecef_top_defines.svh
// Assertion macros shared by the checker.
`ifndef GEODETIC_TO_ECEF_TOP_DEFINES_SVH
`define GEODETIC_TO_ECEF_TOP_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define GCV_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define GCV_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

// Check what reset leaves behind in the next cycle.
`define GCV_ASSERT_RST(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

FILE: src/gcv_pkg.sv
`timescale 1ns / 1ps
package gcv_pkg;

   localparam logic [63:0]        PI_Q32       = 64'h0000_0003_243F_6A89;
   localparam logic signed [63:0] PI4_Q60      = 64'sh0C90_FDAA_2216_8C23;
   localparam logic signed [63:0] GAIN_Q60     = 64'sd700114967507363238;
   localparam logic [63:0]        SEMI_AXIS_MM = 64'd6378137000;
   localparam logic signed [31:0] LAT_MAX      = 32'sd1073741824;
   localparam logic signed [31:0] LAT_MIN      = -32'sd1073741824;

   // Flattening and eccentricity terms, all Q60
   localparam logic [127:0] ONE_Q60_W = 128'd1 << 60;
   localparam logic [127:0] FLAT_W    = (ONE_Q60_W * 128'd1000000000) / 128'd298257223563;
   localparam logic [127:0] OMF_W     = ONE_Q60_W - FLAT_W;
   localparam logic [127:0] OME2_W    = ((OMF_W * OMF_W) + (128'd1 << 59)) >> 60;
   localparam logic [63:0]  OME2_Q60  = OME2_W[63:0];
   localparam logic [63:0]  E2_Q60    = ONE_Q60_W[63:0] - OME2_Q60;

   // Series for 1/sqrt(1-u), Q60
   localparam logic [63:0] SERIES_Q60 [0:6] = '{
      64'd1 << 60, 64'd1 << 59, 64'd3 << 57, 64'd5 << 56,
      64'd35 << 53, 64'd63 << 52, 64'd231 << 50
   };

   typedef struct packed {
      logic [63:0] cl_mag;
      logic        cl_neg;
      logic [63:0] sl_mag;
      logic        sl_neg;
      logic [63:0] co_mag;
      logic        co_neg;
      logic [63:0] so_mag;
      logic        so_neg;
   } side_type;

   // Round half up and drop sh bits, keep 64
   function automatic logic [63:0] rnd_shr(input logic [127:0] prod, input int unsigned sh);
      logic [127:0] sum;
      sum = (prod + (128'd1 << (sh - 1))) >> sh;
      return sum[63:0];
   endfunction

   function automatic logic [63:0] mag64(input logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   function automatic logic [63:0] q20_of_mm(input logic [31:0] h);
      return {{12{h[31]}}, h, 20'd0};
   endfunction

   function automatic logic [34:0] to_mm35(input logic [63:0] r, input logic neg);
      logic [63:0] m;
      m = (r + 64'd524288) >> 20;
      if (neg) begin
         m = 64'd0 - m;
      end
      return m[34:0];
   endfunction

   // Elaboration only: restoring long division
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         if (r >= d) begin
            r = r - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(2^-idx) in Q60 from the truncated arctangent series
   function automatic logic [63:0] atan_q60(input int idx);
      logic [63:0] acc;
      logic [63:0] term;
      int          e;
      acc = '0;
      if (idx <= 0) begin
         return PI4_Q60;
      end
      for (int k = 0; k < 31; k++) begin
         e = 60 - idx * (2 * k + 1);
         if (e >= 0) begin
            term = udiv64(64'd1 << e, 64'(2 * k + 1));
            acc  = (k % 2 == 1) ? (acc - term) : (acc + term);
         end
      end
      return acc;
   endfunction

endpackage

FILE: src/gcv_if.sv
`timescale 1ns / 1ps
interface gcv_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] latitude;
   logic signed [31:0] longitude;
   logic signed [31:0] height_mm;

   modport source (output valid, output latitude, output longitude, output height_mm,
                   input ready);
   modport sink   (input valid, input latitude, input longitude, input height_mm,
                   output ready);
endinterface

interface gcv_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [34:0] ecef_x_mm;
   logic signed [34:0] ecef_y_mm;
   logic signed [34:0] ecef_z_mm;

   modport source (output valid, output ecef_x_mm, output ecef_y_mm, output ecef_z_mm,
                   input ready);
   modport sink   (input valid, input ecef_x_mm, input ecef_y_mm, input ecef_z_mm,
                   output ready);
endinterface

FILE: src/gcv_delay.sv
`timescale 1ns / 1ps
module gcv_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);
   logic [WIDTH-1:0] stage_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            stage_ff[i] <= stage_ff[i-1];
         end
      end
   end

   assign q = stage_ff[DEPTH-1];
endmodule

FILE: src/gcv_mul.sv
`timescale 1ns / 1ps
module gcv_mul (
   input  logic         clock,
   input  logic         en,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic [127:0] prod
);
   logic [63:0]  p00_ff;
   logic [63:0]  p01_ff;
   logic [63:0]  p10_ff;
   logic [63:0]  p11_ff;
   logic [127:0] prod_ff;

   // Partial products first, then combine
   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff  <= 64'(a[31:0])  * 64'(b[31:0]);
         p01_ff  <= 64'(a[31:0])  * 64'(b[63:32]);
         p10_ff  <= 64'(a[63:32]) * 64'(b[31:0]);
         p11_ff  <= 64'(a[63:32]) * 64'(b[63:32]);
         prod_ff <= {p11_ff, p00_ff} + {32'd0, p01_ff, 32'd0} + {32'd0, p10_ff, 32'd0};
      end
   end

   assign prod = prod_ff;
endmodule

FILE: src/gcv_cordic.sv
`timescale 1ns / 1ps
module gcv_cordic #(
   parameter int STAGES = 32
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [63:0] angle,
   output logic signed [63:0] cos_q60,
   output logic signed [63:0] sin_q60
);
   import gcv_pkg::*;

   logic signed [63:0] x_ff [0:STAGES-1];
   logic signed [63:0] y_ff [0:STAGES-1];
   logic signed [63:0] z_ff [0:STAGES-2];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic signed [63:0] ATAN = atan_q60(i);
      logic signed [63:0] x_prev;
      logic signed [63:0] y_prev;
      logic signed [63:0] z_prev;

      if (i == 0) begin : g_first
         assign x_prev = GAIN_Q60;
         assign y_prev = '0;
         assign z_prev = angle;
      end else begin : g_next
         assign x_prev = x_ff[i-1];
         assign y_prev = y_ff[i-1];
         assign z_prev = z_ff[i-1];
      end

      // Rotate towards zero residual angle
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_prev[63]) begin
               x_ff[i] <= x_prev - (y_prev >>> i);
               y_ff[i] <= y_prev + (x_prev >>> i);
            end else begin
               x_ff[i] <= x_prev + (y_prev >>> i);
               y_ff[i] <= y_prev - (x_prev >>> i);
            end
         end
      end

      if (i < STAGES - 1) begin : g_angle
         always_ff @(posedge clock) begin
            if (en) begin
               z_ff[i] <= z_prev[63] ? (z_prev + ATAN) : (z_prev - ATAN);
            end
         end
      end
   end

   assign cos_q60 = x_ff[STAGES-1];
   assign sin_q60 = y_ff[STAGES-1];
endmodule

FILE: src/geodetic_to_ecef_top.sv
`timescale 1ns / 1ps
// WGS84 geodetic to earth-centred conversion.
// req_ch carries one position per request: latitude and longitude in units of
// 2^-31 semicircle, height in millimetres. rsp_ch returns x, y and z in
// millimetres, rounded to nearest, one response per request and in order.
// The pipeline is input folding, angle scaling, two CORDIC rotators of
// CORDIC_STAGES stages, and a chain of eleven split 64-bit multipliers for
// the radius series and the final products. A new request is taken in every
// cycle unless a waiting response is held; each conversion stands on its own.
// Reset is synchronous and clears the valid bits only; no response is shown
// until a request has gone all the way through.
// When the receiver holds rsp_ch.ready low with a response waiting, the whole
// pipeline holds and req_ch.ready drops in the same cycle; nothing is lost or
// repeated, and flow resumes as soon as the response is taken.
module geodetic_to_ecef_top #(
   parameter int CORDIC_STAGES = 32
) (
   input logic         clock,
   input logic         reset,
   gcv_req_if.sink     req_ch,
   gcv_rsp_if.source   rsp_ch
);
   import gcv_pkg::*;

   localparam int LATENCY  = CORDIC_STAGES + 41;
   localparam int FLIP_DLY = CORDIC_STAGES + 4;
   localparam int H_DLY    = CORDIC_STAGES + 32;

   logic               en;
   logic [LATENCY-1:0] vld_ff;

   // Advance everything unless a response is held by the receiver
   assign en           = !vld_ff[LATENCY-1] || rsp_ch.ready;
   assign req_ch.ready = en;
   assign rsp_ch.valid = vld_ff[LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LATENCY-2:0], req_ch.valid};
      end
   end

   // ---- Clamp latitude to the poles, fold longitude into +-90 degrees ----
   logic signed [31:0] lat_in;
   logic signed [31:0] lon_in;
   logic               flip_in;
   logic signed [31:0] lat_ff;
   logic signed [31:0] lon_ff;
   logic               flip_ff;
   logic [31:0]        h_ff;

   always_comb begin
      if (req_ch.latitude > LAT_MAX) begin
         lat_in = LAT_MAX;
      end else if (req_ch.latitude < LAT_MIN) begin
         lat_in = LAT_MIN;
      end else begin
         lat_in = req_ch.latitude;
      end
      // Moving by one semicircle just toggles the top bit
      flip_in = (req_ch.longitude > LAT_MAX) || (req_ch.longitude < LAT_MIN);
      lon_in  = flip_in ? {~req_ch.longitude[31], req_ch.longitude[30:0]}
                        : req_ch.longitude;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lat_ff  <= lat_in;
         lon_ff  <= lon_in;
         flip_ff <= flip_in;
         h_ff    <= req_ch.height_mm;
      end
   end

   // ---- Angle to radians: magnitude times pi, then sign back ----
   logic [31:0]  lat_abs;
   logic [31:0]  lon_abs;
   logic [30:0]  lat_mag_ff;
   logic [30:0]  lon_mag_ff;
   logic [1:0]   ang_neg_ff;
   logic [1:0]   ang_neg_d;
   logic [127:0] lat_pi_prod;
   logic [127:0] lon_pi_prod;
   logic [63:0]  lat_r;
   logic [63:0]  lon_r;
   logic signed [63:0] lat_rad_ff;
   logic signed [63:0] lon_rad_ff;

   assign lat_abs = lat_ff[31] ? (32'd0 - lat_ff) : lat_ff;
   assign lon_abs = lon_ff[31] ? (32'd0 - lon_ff) : lon_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         lat_mag_ff <= lat_abs[30:0];
         lon_mag_ff <= lon_abs[30:0];
         ang_neg_ff <= {lat_ff[31], lon_ff[31]};
      end
   end

   gcv_mul u_mul_lat_pi (.clock, .en, .a({33'd0, lat_mag_ff}), .b(PI_Q32), .prod(lat_pi_prod));
   gcv_mul u_mul_lon_pi (.clock, .en, .a({33'd0, lon_mag_ff}), .b(PI_Q32), .prod(lon_pi_prod));

   gcv_delay #(.WIDTH(2), .DEPTH(2)) u_dly_ang_neg (
      .clock, .en, .d(ang_neg_ff), .q(ang_neg_d)
   );

   assign lat_r = rnd_shr(lat_pi_prod, 3);
   assign lon_r = rnd_shr(lon_pi_prod, 3);

   always_ff @(posedge clock) begin
      if (en) begin
         lat_rad_ff <= ang_neg_d[1] ? (64'd0 - lat_r) : lat_r;
         lon_rad_ff <= ang_neg_d[0] ? (64'd0 - lon_r) : lon_r;
      end
   end

   // ---- Sine and cosine ----
   logic signed [63:0] cl;
   logic signed [63:0] sl;
   logic signed [63:0] co;
   logic signed [63:0] so;
   logic               flip_d;

   gcv_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lat (
      .clock, .en, .angle(lat_rad_ff), .cos_q60(cl), .sin_q60(sl)
   );
   gcv_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lon (
      .clock, .en, .angle(lon_rad_ff), .cos_q60(co), .sin_q60(so)
   );

   gcv_delay #(.WIDTH(1), .DEPTH(FLIP_DLY)) u_dly_flip (
      .clock, .en, .d(flip_ff), .q(flip_d)
   );

   // Split into magnitude and sign; a folded longitude negates both terms
   side_type side_in;
   side_type side_ff;

   always_comb begin
      side_in.cl_mag = mag64(cl);
      side_in.cl_neg = cl[63];
      side_in.sl_mag = mag64(sl);
      side_in.sl_neg = sl[63];
      side_in.co_mag = mag64(co);
      side_in.co_neg = co[63] ^ flip_d;
      side_in.so_mag = mag64(so);
      side_in.so_neg = so[63] ^ flip_d;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_in;
      end
   end

   // ---- u = e2 * sin^2(lat) ----
   logic [127:0] sl2_prod;
   logic [63:0]  sl2_ff;
   logic [127:0] u_prod;
   logic [63:0]  u_ff;

   gcv_mul u_mul_sl2 (.clock, .en, .a(side_ff.sl_mag), .b(side_ff.sl_mag), .prod(sl2_prod));

   always_ff @(posedge clock) begin
      if (en) begin
         sl2_ff <= rnd_shr(sl2_prod, 60);
      end
   end

   gcv_mul u_mul_u (.clock, .en, .a(E2_Q60), .b(sl2_ff), .prod(u_prod));

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff <= rnd_shr(u_prod, 60);
      end
   end

   // ---- Horner chain for 1/sqrt(1-u), one multiplier per coefficient below the top one ----
   logic [63:0]  hu [0:5];
   logic [63:0]  hp_ff [1:6];
   logic [127:0] h_prod [0:5];

   assign hu[0] = u_ff;

   for (genvar j = 0; j < 6; j++) begin : g_horner
      logic [63:0] coef_b;

      if (j == 0) begin : g_top
         assign coef_b = SERIES_Q60[6];
      end else begin : g_acc
         assign coef_b = hp_ff[j];
      end

      gcv_mul u_mul_step (.clock, .en, .a(hu[j]), .b(coef_b), .prod(h_prod[j]));

      always_ff @(posedge clock) begin
         if (en) begin
            hp_ff[j+1] <= SERIES_Q60[5-j] + rnd_shr(h_prod[j], 60);
         end
      end

      if (j < 5) begin : g_u_dly
         gcv_delay #(.WIDTH(64), .DEPTH(3)) u_dly_u (
            .clock, .en, .d(hu[j]), .q(hu[j+1])
         );
      end
   end

   // ---- N in mm Q20, then N+h and N(1-e2)+h ----
   logic [127:0] nq_prod;
   logic [63:0]  nq_ff;
   logic [31:0]  h_d27;
   logic [31:0]  h_d29;
   logic [63:0]  nh_in;
   logic [63:0]  nh_mag_ff;
   logic         nh_neg_ff;
   logic [127:0] nz_prod;
   logic [63:0]  nz_ff;

   gcv_mul u_mul_nq (.clock, .en, .a(SEMI_AXIS_MM), .b(hp_ff[6]), .prod(nq_prod));

   always_ff @(posedge clock) begin
      if (en) begin
         nq_ff <= rnd_shr(nq_prod, 40);
      end
   end

   gcv_delay #(.WIDTH(32), .DEPTH(H_DLY)) u_dly_h_a (.clock, .en, .d(h_ff), .q(h_d27));
   gcv_delay #(.WIDTH(32), .DEPTH(2))     u_dly_h_b (.clock, .en, .d(h_d27), .q(h_d29));

   assign nh_in = nq_ff + q20_of_mm(h_d27);

   always_ff @(posedge clock) begin
      if (en) begin
         nh_mag_ff <= mag64(nh_in);
         nh_neg_ff <= nh_in[63];
      end
   end

   gcv_mul u_mul_nz (.clock, .en, .a(nq_ff), .b(OME2_Q60), .prod(nz_prod));

   always_ff @(posedge clock) begin
      if (en) begin
         nz_ff <= rnd_shr(nz_prod, 60) + q20_of_mm(h_d29);
      end
   end

   // ---- t = (N+h) cos(lat), and z term magnitude ----
   side_type     side28;
   side_type     side31;
   logic [127:0] t_prod;
   logic         t_neg_d;
   logic [63:0]  t_mag_ff;
   logic         t_neg_ff;
   logic [63:0]  nz_mag_ff;
   logic         nz_neg_ff;

   gcv_delay #(.WIDTH($bits(side_type)), .DEPTH(28)) u_dly_side_a (
      .clock, .en, .d(side_ff), .q(side28)
   );
   gcv_delay #(.WIDTH($bits(side_type)), .DEPTH(3)) u_dly_side_b (
      .clock, .en, .d(side28), .q(side31)
   );

   gcv_mul u_mul_t (.clock, .en, .a(nh_mag_ff), .b(side28.cl_mag), .prod(t_prod));

   gcv_delay #(.WIDTH(1), .DEPTH(2)) u_dly_t_neg (
      .clock, .en, .d(nh_neg_ff ^ side28.cl_neg), .q(t_neg_d)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         t_mag_ff  <= rnd_shr(t_prod, 60);
         t_neg_ff  <= t_neg_d;
         nz_mag_ff <= mag64(nz_ff);
         nz_neg_ff <= nz_ff[63];
      end
   end

   // ---- Final products and rounding to millimetres ----
   logic [127:0] x_prod;
   logic [127:0] y_prod;
   logic [127:0] z_prod;
   logic [2:0]   fin_neg;
   logic [63:0]  xr_ff;
   logic [63:0]  yr_ff;
   logic [63:0]  zr_ff;
   logic signed [34:0] x_mm_ff;
   logic signed [34:0] y_mm_ff;
   logic signed [34:0] z_mm_ff;

   gcv_mul u_mul_x (.clock, .en, .a(t_mag_ff),  .b(side31.co_mag), .prod(x_prod));
   gcv_mul u_mul_y (.clock, .en, .a(t_mag_ff),  .b(side31.so_mag), .prod(y_prod));
   gcv_mul u_mul_z (.clock, .en, .a(nz_mag_ff), .b(side31.sl_mag), .prod(z_prod));

   gcv_delay #(.WIDTH(3), .DEPTH(3)) u_dly_fin_neg (
      .clock, .en,
      .d({t_neg_ff ^ side31.co_neg, t_neg_ff ^ side31.so_neg, nz_neg_ff ^ side31.sl_neg}),
      .q(fin_neg)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         xr_ff   <= rnd_shr(x_prod, 60);
         yr_ff   <= rnd_shr(y_prod, 60);
         zr_ff   <= rnd_shr(z_prod, 60);
         x_mm_ff <= to_mm35(xr_ff, fin_neg[2]);
         y_mm_ff <= to_mm35(yr_ff, fin_neg[1]);
         z_mm_ff <= to_mm35(zr_ff, fin_neg[0]);
      end
   end

   assign rsp_ch.ecef_x_mm = x_mm_ff;
   assign rsp_ch.ecef_y_mm = y_mm_ff;
   assign rsp_ch.ecef_z_mm = z_mm_ff;
endmodule

FILE: src/gcv_checker.sv
`timescale 1ns / 1ps
`include "geodetic_to_ecef_top_defines.svh"
module gcv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [34:0] rsp_x,
   input logic [34:0] rsp_y,
   input logic [34:0] rsp_z
);
   // Hold a stalled response, and its payload
   `GCV_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `GCV_ASSERT_NXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_x) && $stable(rsp_y) && $stable(rsp_z), "response changed while stalled")
   // Take requests exactly when the output stage can move
   `GCV_ASSERT_IMP(a_ready_rule, req_valid || !req_valid, req_ready == (!rsp_valid || rsp_ready), "request ready does not follow output stall")
   // Drop all in-flight work on reset
   `GCV_ASSERT_RST(a_reset_empty, !rsp_valid, "response shown straight after reset")
endmodule

bind geodetic_to_ecef_top gcv_checker u_gcv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_x     (rsp_ch.ecef_x_mm),
   .rsp_y     (rsp_ch.ecef_y_mm),
   .rsp_z     (rsp_ch.ecef_z_mm)
);

FILE: tb/sv/gcv_ecef_checker.sv
`timescale 1ns / 1ps
module gcv_ecef_checker #(
   parameter int CORDIC_STAGES = 32
) (
   input  logic      clock,
   input  logic      reset,
   gcv_req_if        req_ch,
   gcv_rsp_if        rsp_ch,
   output int        mismatches,
   output int        pending,
   output int        checked
);

   typedef struct packed {
      logic signed [34:0] x;
      logic signed [34:0] y;
      logic signed [34:0] z;
   } ecef_type;

   localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
   localparam logic [63:0] PI_Q32  = 64'h0000_0003_243F_6A89;
   localparam logic [63:0] A_MM    = 64'd6378137000;

   ecef_type                ecef_due [$];
   logic signed [63:0]      atan_tab [0:63];
   logic [63:0]             ome2_q60;
   logic [63:0]             e2_q60;

   // rounded (a*b) >> sh on unsigned magnitudes
   function automatic logic [63:0] mulr(input logic [63:0] a, input logic [63:0] b,
                                        input int sh);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      p = (p + (128'd1 << (sh - 1))) >> sh;
      return p[63:0];
   endfunction

   function automatic logic [63:0] absv(input logic signed [63:0] v);
      return v[63] ? 64'd0 - 64'(v) : 64'(v);
   endfunction

   function automatic logic signed [63:0] smulr(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
      logic signed [63:0] r;
      r = mulr(absv(a), absv(b), 60);
      return (a[63] != b[63]) ? -r : r;
   endfunction

   function automatic logic signed [63:0] to_radians(input logic signed [63:0] a);
      logic signed [63:0] r;
      r = (absv(a) * PI_Q32 + 64'd4) >> 3;
      return a[63] ? -r : r;
   endfunction

   function automatic logic [34:0] round_mm(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = (absv(v) + (64'd1 << 19)) >> 20;
      if (v[63]) begin
         r = -r;
      end
      return r[34:0];
   endfunction

   task automatic rotate(input logic signed [63:0] ang,
                         output logic signed [63:0] c, output logic signed [63:0] s);
      logic signed [63:0] x, y, z, dx, dy;
      x = 64'sd700114967507363238;
      y = 0;
      z = ang;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (!z[63]) begin
            x = x - dx; y = y + dy; z = z - atan_tab[i];
         end else begin
            x = x + dx; y = y - dy; z = z + atan_tab[i];
         end
      end
      c = x;
      s = y;
   endtask

   task automatic convert(input logic signed [31:0] lat_in, input logic signed [31:0] lon_in,
                          input logic signed [31:0] h_in, output ecef_type res);
      logic signed [63:0] lat, lon, hq, cl, sl, co, so, nq, nh, nz, t;
      logic [63:0]        u, p;
      logic               flip;
      lat  = lat_in;
      lon  = lon_in;
      hq   = 64'(h_in) <<< 20;
      flip = 1'b0;
      // clamp beyond the poles, fold far longitudes by a semicircle
      if (lat > 64'sd1073741824) lat = 64'sd1073741824;
      if (lat < -64'sd1073741824) lat = -64'sd1073741824;
      if (lon > 64'sd1073741824) begin
         lon = lon - 64'sd2147483648; flip = 1'b1;
      end else if (lon < -64'sd1073741824) begin
         lon = lon + 64'sd2147483648; flip = 1'b1;
      end
      rotate(to_radians(lat), cl, sl);
      rotate(to_radians(lon), co, so);
      if (flip) begin
         co = -co; so = -so;
      end
      u = mulr(e2_q60, mulr(absv(sl), absv(sl), 60), 60);
      p = 64'd231 << 50;
      p = (64'd63 << 52) + mulr(u, p, 60);
      p = (64'd35 << 53) + mulr(u, p, 60);
      p = (64'd5 << 56) + mulr(u, p, 60);
      p = (64'd3 << 57) + mulr(u, p, 60);
      p = (64'd1 << 59) + mulr(u, p, 60);
      p = ONE_Q60 + mulr(u, p, 60);
      nq = mulr(A_MM, p, 40);
      nh = nq + hq;
      nz = mulr(nq, ome2_q60, 60) + hq;
      t  = smulr(nh, cl);
      res.x = round_mm(smulr(t, co));
      res.y = round_mm(smulr(t, so));
      res.z = round_mm(smulr(nz, sl));
   endtask

   initial begin
      logic [127:0] f;
      logic [63:0]  omf;
      atan_tab[0] = 64'sh0C90_FDAA_2216_8C23;
      for (int i = 1; i < 64; i++) begin
         atan_tab[i] = 0;
         for (int k = 0; 60 - i * (2 * k + 1) >= 0; k++) begin
            if (k % 2) atan_tab[i] -= (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
            else       atan_tab[i] += (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
         end
      end
      f        = (128'd1 << 60) * 128'd1000000000 / 128'd298257223563;
      omf      = ONE_Q60 - f[63:0];
      ome2_q60 = mulr(omf, omf, 60);
      e2_q60   = ONE_Q60 - ome2_q60;
   end

   assign pending = ecef_due.size();

   always @(posedge clock) begin
      ecef_type exp_r, got;
      if (reset) begin
         mismatches <= 0;
         checked    <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            convert(req_ch.latitude, req_ch.longitude, req_ch.height_mm, exp_r);
            ecef_due.push_back(exp_r);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.ecef_x_mm, rsp_ch.ecef_y_mm, rsp_ch.ecef_z_mm};
            checked <= checked + 1;
            if (ecef_due.size() == 0) begin
               if (mismatches < 10) $display("unexpected response x=%0d y=%0d z=%0d",
                                             got.x, got.y, got.z);
               mismatches <= mismatches + 1;
            end else begin
               exp_r = ecef_due.pop_front();
               if (got !== exp_r) begin
                  if (mismatches < 10)
                     $display("mismatch: exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                              exp_r.x, exp_r.y, exp_r.z, got.x, got.y, got.z);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

FILE: tb/sv/geodetic_to_ecef_top_tb.sv
`timescale 1ns / 1ps
module geodetic_to_ecef_top_tb;

   localparam int LATENCY   = 32 + 41;
   localparam int MAX_CYCLE = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   int   cycle_count    = 0;
   int   mismatches, pending, checked;
   int   sent = 0;

   gcv_req_if req_ch ();
   gcv_rsp_if rsp_ch ();

   geodetic_to_ecef_top #(.CORDIC_STAGES(32)) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   gcv_ecef_checker #(.CORDIC_STAGES(32)) i_checker (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .mismatches(mismatches),
      .pending   (pending),
      .checked   (checked)
   );

   always #10 clock = ~clock;

   // Receiver: stall at the rate of the current phase
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Watchdog: give up well past the slowest plausible run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLE) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL geodetic_to_ecef_top");
         $finish;
      end
   end

   // Present one request, hold it until taken, then maybe idle.
   // Ready is judged at the falling edge, clear of the rising-edge updates.
   task automatic send_request(input logic [31:0] lat, input logic [31:0] lon,
                               input logic [31:0] h);
      req_ch.valid     <= 1'b1;
      req_ch.latitude  <= lat;
      req_ch.longitude <= lon;
      req_ch.height_mm <= h;
      @(negedge clock);
      while (!req_ch.ready) @(negedge clock);
      @(posedge clock);
      sent++;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
   endtask

   // Drop the valid and hold until every outstanding request has answered
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic random_phase(input int idle_pct, input int stall_pct, input int count);
      logic [31:0] lat, lon, h;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         // mostly legal latitudes, some beyond the poles
         if ($urandom_range(0, 99) < 75) lat = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
         else                            lat = $urandom;
         lon = $urandom;
         // mostly terrestrial heights, the rest anywhere in 32 bits
         if ($urandom_range(0, 99) < 60) h = $urandom_range(0, 20_000_000) - 10_000_000;
         else                            h = $urandom;
         send_request(lat, lon, h);
      end
   endtask

   initial begin
      logic [31:0] lat_edge [0:6];
      logic [31:0] lon_edge [0:6];
      logic [31:0] h_edge   [0:2];
      lat_edge = '{32'h0, 32'h4000_0000, 32'hC000_0000, 32'h4000_0001, 32'hBFFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF};
      lon_edge = '{32'h0, 32'h4000_0000, 32'hC000_0000, 32'h4000_0001, 32'hBFFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF};
      h_edge   = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000};
      req_ch.valid     <= 1'b0;
      req_ch.latitude  <= '0;
      req_ch.longitude <= '0;
      req_ch.height_mm <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: pole clamps, longitude folds and height extremes
      for (int i = 0; i < 7; i++) begin
         send_request(lat_edge[i], lon_edge[i], h_edge[i % 3]);
         send_request(lat_edge[6 - i], lon_edge[i], h_edge[(i + 1) % 3]);
      end
      send_request(32'h2000_0000, 32'h6000_0000, 32'd1234);
      send_request(32'hE000_0000, 32'hA000_0000, 32'hFFFF_FB2E);
      send_request(32'h1555_5555, 32'h0000_0001, 32'd0);
      drain();

      // Random phases: free flow, slow sender, slow receiver, both jittery
      random_phase(0, 0, 400);
      random_phase(72, 0, 400);
      drain();
      random_phase(0, 72, 400);
      random_phase(11, 11, 400);
      drain();

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (LATENCY + 20) @(posedge clock);
      $display("covered %0d requests and %0d responses: pole clamps, longitude folds,",
               sent, checked);
      $display("height extremes, and sender/receiver stall mixes up to 72 percent");
      if (mismatches == 0 && pending == 0) begin
         $display("PASS geodetic_to_ecef_top");
      end else begin
         $display("FAIL geodetic_to_ecef_top");
      end
      $finish;
   end

endmodule
